>>> hdl/rx_fifo_idle_timeout_framer_core_defines.svh
// Assertion helpers used by the framer controller RTL.
// Both expect clk_i and rst_ni in scope.
`ifndef RX_FIFO_IDLE_TIMEOUT_FRAMER_CORE_DEFINES_SVH
`define RX_FIFO_IDLE_TIMEOUT_FRAMER_CORE_DEFINES_SVH

// Same-cycle implication.
`define RFITF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RFITF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rfitf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rfitf_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 8192;
  localparam int unsigned MAX_BURST_DEF  = 64;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SPACE_W    = 7;
  localparam int unsigned TMR_W      = 16;
  localparam int unsigned THR_W      = 14;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TMR_W-1:0] BREAK_TIME_RST = 16'd15;
  localparam logic [THR_W-1:0] FLUSH_THR_RST  = 14'd1500;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POLL = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FLUSH_THR  = 1'b1;

  typedef struct packed {
    logic [TMR_W-1:0] break_time;
    logic [THR_W-1:0] flush_thr;
  } rfitf_cfg_t;

  typedef struct packed {
    logic              load;
    logic [DATA_W-1:0] data;
    logic              last;
  } rfitf_out_t;

endpackage

`default_nettype wire

>>> hdl/rfitf_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module rfitf_mem import rfitf_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF,
  localparam int unsigned AW = $clog2(FIFO_DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output      logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [FIFO_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/rfitf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "rx_fifo_idle_timeout_framer_core_defines.svh"

module rfitf_ctrl import rfitf_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int unsigned MAX_BURST  = MAX_BURST_DEF,
  localparam int unsigned AW    = $clog2(FIFO_DEPTH),
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [CMD_W-1:0]   cmd_i,
  input  wire logic [DATA_W-1:0]  data_byte_i,
  input  wire logic [SPACE_W-1:0] sink_space_i,
  input  wire rfitf_cfg_t         cfg_i,
  input  wire logic               out_free_i,
  output      rfitf_out_t         out_req_o,
  output      logic               mem_we_o,
  output      logic [AW-1:0]      mem_waddr_o,
  output      logic [DATA_W-1:0]  mem_wdata_o,
  output      logic               mem_re_o,
  output      logic [AW-1:0]      mem_raddr_o,
  input  wire logic [DATA_W-1:0]  mem_rdata_i
);

  localparam int unsigned CMP_W = (CNT_W > TMR_W) ? CNT_W : TMR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_THR  = 3'd1;  // fill below threshold?
  localparam logic [2:0] S_REM  = 3'd2;  // fill grown since remembered fill?
  localparam logic [2:0] S_TMR  = 3'd3;  // timer past break time?
  localparam logic [2:0] S_LIM  = 3'd4;  // burst = min(space, cap, fill)
  localparam logic [2:0] S_OUT  = 3'd5;  // drain one byte per cycle while output is free

  logic [2:0]         state_q, state_d;
  logic [AW-1:0]      wr_idx_q, wr_idx_d;
  logic [AW-1:0]      rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [TMR_W-1:0]   timer_q, timer_d;
  logic [SPACE_W-1:0] space_q, space_d;
  logic [SPACE_W-1:0] cnt_q, cnt_d;

  logic [CMP_W-1:0]   cmp_a, cmp_b;
  logic               cmp_lt;
  logic [SPACE_W-1:0] cap_space;
  logic [SPACE_W-1:0] burst_n;
  logic               accept;
  logic               last_byte;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] idx);
    if (idx == AW'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return idx + AW'(1);
  endfunction

  // Shared comparator, operands picked by the sequencer step
  always_comb begin
    cmp_a = '0;
    cmp_b = '0;
    case (state_q)
      S_THR: begin
        cmp_a = CMP_W'(fill_q);
        cmp_b = CMP_W'(cfg_i.flush_thr);
      end
      S_REM: begin
        cmp_a = CMP_W'(rem_q);
        cmp_b = CMP_W'(fill_q);
      end
      S_TMR: begin
        cmp_a = CMP_W'(cfg_i.break_time);
        cmp_b = CMP_W'(timer_q);
      end
      S_LIM: begin
        cmp_a = CMP_W'(fill_q);
        cmp_b = CMP_W'(cap_space);
      end
      default: begin
      end
    endcase
  end

  assign cmp_lt    = (cmp_a < cmp_b);
  assign cap_space = (space_q > SPACE_W'(MAX_BURST)) ? SPACE_W'(MAX_BURST) : space_q;
  // fill below cap means fill fits in the burst counter
  assign burst_n   = cmp_lt ? SPACE_W'(fill_q) : cap_space;
  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign last_byte = (cnt_q == SPACE_W'(1));

  assign in_stall_o  = (state_q != S_IDLE);
  assign mem_waddr_o = wr_idx_q;
  assign mem_wdata_o = data_byte_i;
  assign mem_raddr_o = rd_idx_q;

  always_comb begin
    state_d   = state_q;
    wr_idx_d  = wr_idx_q;
    rd_idx_d  = rd_idx_q;
    fill_d    = fill_q;
    rem_d     = rem_q;
    timer_d   = timer_q;
    space_d   = space_q;
    cnt_d     = cnt_q;
    mem_we_o  = 1'b0;
    mem_re_o  = 1'b0;
    out_req_o = '{load: 1'b0, data: mem_rdata_i, last: last_byte};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_PUSH: begin
              if (fill_q != CNT_W'(FIFO_DEPTH)) begin
                mem_we_o = 1'b1;
                wr_idx_d = adv(wr_idx_q);
                fill_d   = fill_q + CNT_W'(1);
              end
            end
            CMD_TICK: begin
              if (timer_q != '1) begin
                timer_d = timer_q + TMR_W'(1);
              end
            end
            CMD_POLL: begin
              space_d = sink_space_i;
              if (fill_q != '0) begin
                state_d = S_THR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_THR: begin
        state_d = cmp_lt ? S_REM : S_LIM;
      end
      S_REM: begin
        if (cmp_lt) begin
          timer_d = '0;
          rem_d   = fill_q;
          state_d = S_IDLE;
        end else begin
          state_d = S_TMR;
        end
      end
      S_TMR: begin
        state_d = cmp_lt ? S_LIM : S_IDLE;
      end
      S_LIM: begin
        cnt_d = burst_n;
        if (burst_n == '0) begin
          // flush with nothing to send still restarts the timer
          timer_d = '0;
          rem_d   = fill_q;
          state_d = S_IDLE;
        end else begin
          mem_re_o = 1'b1;
          rd_idx_d = adv(rd_idx_q);
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free_i) begin
          out_req_o.load = 1'b1;
          fill_d         = fill_q - CNT_W'(1);
          cnt_d          = cnt_q - SPACE_W'(1);
          if (last_byte) begin
            timer_d = '0;
            rem_d   = fill_q - CNT_W'(1);
            state_d = S_IDLE;
          end else begin
            // fetch the next byte while this one goes out
            mem_re_o = 1'b1;
            rd_idx_d = adv(rd_idx_q);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      fill_q   <= '0;
      rem_q    <= '0;
      timer_q  <= '0;
      space_q  <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      fill_q   <= fill_d;
      rem_q    <= rem_d;
      timer_q  <= timer_d;
      space_q  <= space_d;
      cnt_q    <= cnt_d;
    end
  end

  `RFITF_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CNT_W'(FIFO_DEPTH), "fill exceeds depth")
  `RFITF_ASSERT_IMP(a_load_free, out_req_o.load, out_free_i, "load into busy output")
  `RFITF_ASSERT_IMP(a_drain_cnt, state_q == S_OUT, cnt_q != '0 && CNT_W'(cnt_q) <= fill_q, "bad drain count")
  `RFITF_ASSERT_NXT(a_flush_end, out_req_o.load && out_req_o.last, state_q == S_IDLE && rem_q == fill_q && timer_q == '0, "flush end bookkeeping")

endmodule

`default_nettype wire

>>> hdl/rx_fifo_idle_timeout_framer_core.sv
// Push and tick requests leave the block idle; it is ready again the next cycle.
// A poll on an empty store leaves the block idle. Otherwise a poll runs two to four
// compare steps on one shared comparator; if it drains, the S_LIM step issues the
// first byte store read, then one byte goes out per cycle while the output is not
// stalled.
// Reset clears pointers, fill, remembered fill and idle timer and restores the
// registers to their defaults; the byte store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module rx_fifo_idle_timeout_framer_core import rfitf_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int unsigned MAX_BURST  = MAX_BURST_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [CMD_W-1:0]      cmd_i,
  input  wire logic [DATA_W-1:0]     data_byte_i,
  input  wire logic [SPACE_W-1:0]    sink_space_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [DATA_W-1:0]     out_byte_o,
  output      logic                  last_in_run_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(FIFO_DEPTH);

  rfitf_cfg_t        cfg_q;
  rfitf_out_t        out_req;
  logic              out_valid_q;
  logic [DATA_W-1:0] out_byte_q;
  logic              out_last_q;
  logic              out_free;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.break_time <= BREAK_TIME_RST;
      cfg_q.flush_thr  <= FLUSH_THR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BREAK_TIME: cfg_q.break_time <= cfg_wdata_i;
        REG_FLUSH_THR:  cfg_q.flush_thr  <= cfg_wdata_i[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rfitf_mem #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rfitf_ctrl #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .MAX_BURST  (MAX_BURST)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .data_byte_i  (data_byte_i),
    .sink_space_i (sink_space_i),
    .cfg_i        (cfg_q),
    .out_free_i   (out_free),
    .out_req_o    (out_req),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // Output register: free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_req.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_req.load) begin
      out_byte_q <= out_req.data;
      out_last_q <= out_req.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_in_run_o = out_last_q;

endmodule

`default_nettype wire
